// ===== hdl/drh_pkg.sv =====
`default_nettype none

package drh_pkg;

    localparam logic [1:0] CMD_RECORD = 2'd0;
    localparam logic [1:0] CMD_FINISH = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    localparam logic [9:0]  RUN_MAX = 10'd1023;
    localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] chrom_id;
        logic [31:0] start_pos;
        logic [31:0] stop_pos;
        logic [9:0]  bin_index;
    } t_in_word;

    typedef struct packed {
        logic        unsorted_flag;
        logic [31:0] reads_total;
        logic [31:0] bin_count;
        logic [9:0]  run_so_far;
    } t_out_word;

    // status after one word, travels beside the bin lookup
    typedef struct packed {
        logic        unsorted_flag;
        logic [31:0] reads_total;
        logic [9:0]  run_so_far;
    } t_status;

    // histogram operation requested by one word
    typedef struct packed {
        logic inc;
        logic rd;
    } t_hist_op;

endpackage

`default_nettype wire

// ===== hdl/drh_ram.sv =====
`default_nettype none

module drh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/drh_track.sv =====
`default_nettype none

module drh_track #(
    parameter int HIST_BINS = 1024,
    localparam int AW = $clog2(HIST_BINS)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic              i_cfg_wr_data,
    input  wire logic              i_accept,
    input  wire drh_pkg::t_in_word i_word,
    output drh_pkg::t_hist_op      o_op,
    output logic      [AW-1:0]     o_addr,
    output drh_pkg::t_status       o_status
);

    logic        r_paired;
    logic [15:0] r_last_chrom;
    logic [31:0] r_last_start;
    logic [31:0] r_last_stop;
    logic [9:0]  r_run;
    logic        r_have_last;
    logic [31:0] r_total;
    logic        r_err;

    logic [15:0] n_last_chrom;
    logic [31:0] n_last_start;
    logic [31:0] n_last_stop;
    logic [9:0]  n_run;
    logic        n_have_last;
    logic [31:0] n_total;
    logic        n_err;

    logic back;
    logic differ;
    logic run_clamp;

    assign back = (i_word.chrom_id == r_last_chrom) && (i_word.start_pos < r_last_start)
                  && (!r_paired || (i_word.stop_pos < r_last_stop));
    assign differ = (i_word.chrom_id != r_last_chrom) || (i_word.start_pos != r_last_start)
                    || (r_paired && (i_word.stop_pos != r_last_stop));

    // runs longer than the top bin land in it
    assign run_clamp = {7'd0, r_run} > 17'(HIST_BINS - 1);

    always_comb begin
        n_last_chrom = r_last_chrom;
        n_last_start = r_last_start;
        n_last_stop  = r_last_stop;
        n_run        = r_run;
        n_have_last  = r_have_last;
        n_total      = r_total;
        n_err        = r_err;
        o_op         = '0;
        o_addr       = AW'(i_word.bin_index);
        case (i_word.command)
            drh_pkg::CMD_RECORD: begin
                if (r_have_last && back) begin
                    n_err = 1'b1;
                end else begin
                    if (!r_have_last) begin
                        n_have_last = 1'b1;
                        n_run       = 10'd1;
                    end else if (differ) begin
                        o_op.inc = 1'b1;
                        n_run    = 10'd1;
                    end else if (r_run != drh_pkg::RUN_MAX) begin
                        n_run = r_run + 10'd1;
                    end
                    n_last_chrom = i_word.chrom_id;
                    n_last_start = i_word.start_pos;
                    n_last_stop  = i_word.stop_pos;
                    if (r_total != drh_pkg::CNT_MAX) begin
                        n_total = r_total + 32'd1;
                    end
                end
            end
            drh_pkg::CMD_FINISH: begin
                if (r_have_last) begin
                    o_op.inc    = 1'b1;
                    n_have_last = 1'b0;
                    n_run       = 10'd0;
                end
            end
            drh_pkg::CMD_READ: begin
                o_op.rd = {7'd0, i_word.bin_index} < 17'(HIST_BINS);
            end
            default: begin
            end
        endcase
        if (o_op.inc) begin
            o_addr = run_clamp ? AW'(HIST_BINS - 1) : AW'(r_run);
        end
    end

    assign o_status.unsorted_flag = n_err;
    assign o_status.reads_total   = n_total;
    assign o_status.run_so_far    = n_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_paired     <= 1'b0;
            r_last_chrom <= '0;
            r_last_start <= '0;
            r_last_stop  <= '0;
            r_run        <= '0;
            r_have_last  <= 1'b0;
            r_total      <= '0;
            r_err        <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_paired <= i_cfg_wr_data;
            end
            if (i_accept) begin
                r_last_chrom <= n_last_chrom;
                r_last_start <= n_last_start;
                r_last_stop  <= n_last_stop;
                r_run        <= n_run;
                r_have_last  <= n_have_last;
                r_total      <= n_total;
                r_err        <= n_err;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/drh_hist.sv =====
`default_nettype none

module drh_hist #(
    parameter int HIST_BINS = 1024,
    localparam int AW = $clog2(HIST_BINS)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire logic              i_adv,
    input  wire drh_pkg::t_hist_op i_op,
    input  wire logic [AW-1:0]     i_addr,
    output logic                   o_clearing,
    output logic      [31:0]       o_bin_count
);

    logic              r_clearing;
    logic [AW-1:0]     r_clr_addr;
    drh_pkg::t_hist_op r_b_op;
    logic [AW-1:0]     r_b_addr;
    logic              r_byp_valid;
    logic [AW-1:0]     r_byp_addr;
    logic [31:0]       r_byp_data;

    logic          wr_fire;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;
    logic [31:0]   ram_rdata;
    logic [31:0]   cur;
    logic [31:0]   inc_data;

    // the bin written on the edge this read was issued is not yet in the ram output
    assign cur      = (r_byp_valid && (r_byp_addr == r_b_addr)) ? r_byp_data : ram_rdata;
    assign inc_data = (cur == drh_pkg::CNT_MAX) ? cur : cur + 32'd1;
    assign wr_fire  = i_adv && r_b_op.inc;

    assign ram_we    = r_clearing || wr_fire;
    assign ram_waddr = r_clearing ? r_clr_addr : r_b_addr;
    assign ram_wdata = r_clearing ? 32'd0 : inc_data;

    drh_ram #(
        .WIDTH (32),
        .DEPTH (HIST_BINS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (ram_wdata),
        .i_rd_en   (i_accept),
        .i_rd_addr (i_addr),
        .o_rd_data (ram_rdata)
    );

    assign o_clearing  = r_clearing;
    assign o_bin_count = r_b_op.rd ? cur : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_b_op      <= '0;
            r_byp_valid <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(HIST_BINS - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            if (i_adv) begin
                r_b_op      <= i_accept ? i_op : '0;
                r_byp_valid <= wr_fire;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_b_addr   <= i_addr;
            r_byp_addr <= r_b_addr;
            r_byp_data <= inc_data;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/duplicate_run_histogram_core.sv =====
// an accepted word is registered in stage B, then its result in the output register
// throughput: one word per cycle unless stalled; the histogram ram has one read and one write port,
// the bin read for a word is updated as that word leaves stage B, with a one-entry bypass
// reset: synchronous, active low; afterwards a sweep clears all HIST_BINS bins,
// one per cycle, and input words are stalled until the sweep is done
`default_nettype none

module duplicate_run_histogram_core #(
    parameter int HIST_BINS = 1024
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_wr_en,
    input  wire logic               i_cfg_wr_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire drh_pkg::t_in_word  i_in_word,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output drh_pkg::t_out_word      o_out_word
);

    localparam int AW = $clog2(HIST_BINS);

    logic               r_b_valid;
    drh_pkg::t_status   r_b_status;
    logic               r_out_valid;
    drh_pkg::t_out_word r_out_word;

    logic              pipe_en;
    logic              accept;
    logic              clearing;
    drh_pkg::t_hist_op op;
    logic [AW-1:0]     addr;
    drh_pkg::t_status  status;
    logic [31:0]       bin_count;

    assign pipe_en    = !r_b_valid || !r_out_valid || !i_out_stall;
    assign o_in_stall = clearing || !pipe_en;
    assign accept     = i_in_valid && !o_in_stall;

    drh_track #(
        .HIST_BINS (HIST_BINS)
    ) u_track (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (accept),
        .i_word        (i_in_word),
        .o_op          (op),
        .o_addr        (addr),
        .o_status      (status)
    );

    drh_hist #(
        .HIST_BINS (HIST_BINS)
    ) u_hist (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_adv       (pipe_en),
        .i_op        (op),
        .i_addr      (addr),
        .o_clearing  (clearing),
        .o_bin_count (bin_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (pipe_en) begin
                r_b_valid <= accept;
            end
            if (pipe_en && r_b_valid) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_b_status <= status;
        end
        if (pipe_en && r_b_valid) begin
            r_out_word.unsorted_flag <= r_b_status.unsorted_flag;
            r_out_word.reads_total   <= r_b_status.reads_total;
            r_out_word.bin_count     <= bin_count;
            r_out_word.run_so_far    <= r_b_status.run_so_far;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

`default_nettype wire

// ===== tb/tb_duplicate_run_histogram_core.sv =====
`default_nettype none

module tb_duplicate_run_histogram_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          BINS        = 1024;
    localparam logic [1:0]  CMD_UNUSED  = 2'd3;
    localparam int          HOLD_CYCLES = 150;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          TAIL_CYCLES = 8;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_wr_en;
    logic                i_cfg_wr_data;
    logic                i_in_valid;
    logic                o_in_stall;
    drh_pkg::t_in_word   i_in_word;
    logic                o_out_valid;
    logic                i_out_stall;
    drh_pkg::t_out_word  o_out_word;

    duplicate_run_histogram_core #(
        .HIST_BINS(BINS)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_word    (i_in_word),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_word   (o_out_word)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predicted histogram state
    logic [31:0] model_bins [BINS];
    logic [15:0] prev_chrom;
    logic [31:0] prev_start;
    logic [31:0] prev_stop;
    logic [9:0]  open_run;
    logic        run_open;
    logic [31:0] records_seen;
    logic        sort_fault;
    logic        paired_cfg;

    drh_pkg::t_out_word expected_status_q [$];

    int errors          = 0;
    int words_sent      = 0;
    int results_checked = 0;
    int longest_run     = 0;
    int cycle_count     = 0;
    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int hold_requests   = 0;
    int hold_taken      = 0;
    int hold_left       = 0;

    function automatic void close_open_run();
        if (model_bins[open_run] != drh_pkg::CNT_MAX)
            model_bins[open_run] = model_bins[open_run] + 32'd1;
    endfunction

    function automatic drh_pkg::t_out_word predict_word(drh_pkg::t_in_word w);
        drh_pkg::t_out_word r;
        logic               back;
        logic               differ;
        r = '0;
        case (w.command)
            drh_pkg::CMD_RECORD: begin
                back = 1'b0;
                if (run_open) begin
                    back = (w.chrom_id == prev_chrom) && (w.start_pos < prev_start);
                    if (paired_cfg)
                        back = back && (w.stop_pos < prev_stop);
                    if (back) begin
                        sort_fault = 1'b1;
                    end else begin
                        differ = (w.chrom_id != prev_chrom) || (w.start_pos != prev_start);
                        if (paired_cfg)
                            differ = differ || (w.stop_pos != prev_stop);
                        if (differ) begin
                            close_open_run();
                            open_run = 10'd1;
                        end else if (open_run < drh_pkg::RUN_MAX) begin
                            open_run = open_run + 10'd1;
                        end
                    end
                end else begin
                    run_open = 1'b1;
                    open_run = 10'd1;
                end
                if (!back) begin
                    prev_chrom = w.chrom_id;
                    prev_start = w.start_pos;
                    prev_stop  = w.stop_pos;
                    if (records_seen != drh_pkg::CNT_MAX)
                        records_seen = records_seen + 32'd1;
                end
                if (int'(open_run) > longest_run)
                    longest_run = int'(open_run);
            end
            drh_pkg::CMD_FINISH: begin
                if (run_open) begin
                    close_open_run();
                    run_open = 1'b0;
                    open_run = '0;
                end
            end
            drh_pkg::CMD_READ: begin
                if (int'(w.bin_index) < BINS)
                    r.bin_count = model_bins[w.bin_index];
            end
            default: begin
            end
        endcase
        r.unsorted_flag = sort_fault;
        r.reads_total   = records_seen;
        r.run_so_far    = open_run;
        return r;
    endfunction

    function automatic drh_pkg::t_in_word record_word(logic [15:0] c, logic [31:0] s,
                                                      logic [31:0] e);
        drh_pkg::t_in_word w;
        w.command   = drh_pkg::CMD_RECORD;
        w.chrom_id  = c;
        w.start_pos = s;
        w.stop_pos  = e;
        w.bin_index = 10'($urandom);
        return w;
    endfunction

    function automatic drh_pkg::t_in_word command_word(logic [1:0] cmd, logic [9:0] idx);
        drh_pkg::t_in_word w;
        w.command   = cmd;
        w.chrom_id  = 16'($urandom);
        w.start_pos = $urandom;
        w.stop_pos  = $urandom;
        w.bin_index = idx;
        return w;
    endfunction

    // offer one word and wait for it to be taken
    task automatic send_word(drh_pkg::t_in_word w);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        expected_status_q.push_back(predict_word(w));
        words_sent++;
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_status_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_paired_mode(logic v);
        drain_results();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        paired_cfg  = v;
        i_cfg_wr_en <= 1'b0;
    endtask

    // receiver side: random stall, or a long hold-off when asked
    always @(posedge i_clk) begin
        if (hold_requests != hold_taken) begin
            hold_taken  <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic report_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        $display("%0t mismatch %s: expected %0h actual %0h", $time, name, exp_v, act_v);
        errors++;
    endtask

    always @(posedge i_clk) begin
        drh_pkg::t_out_word exp_w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_status_q.size() == 0) begin
                $display("%0t unexpected result word %0h", $time, o_out_word);
                errors++;
            end else begin
                exp_w = expected_status_q.pop_front();
                results_checked++;
                if (o_out_word.unsorted_flag !== exp_w.unsorted_flag)
                    report_field("unsorted_flag", 32'(exp_w.unsorted_flag),
                                 32'(o_out_word.unsorted_flag));
                if (o_out_word.reads_total !== exp_w.reads_total)
                    report_field("reads_total", exp_w.reads_total, o_out_word.reads_total);
                if (o_out_word.bin_count !== exp_w.bin_count)
                    report_field("bin_count", exp_w.bin_count, o_out_word.bin_count);
                if (o_out_word.run_so_far !== exp_w.run_so_far)
                    report_field("run_so_far", 32'(exp_w.run_so_far),
                                 32'(o_out_word.run_so_far));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_status_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic test_after_reset();
        send_word(command_word(drh_pkg::CMD_READ, 10'd0));
        send_word(command_word(drh_pkg::CMD_READ, 10'd1023));
        send_word(command_word(drh_pkg::CMD_FINISH, 10'd0));
        send_word(command_word(CMD_UNUSED, 10'h3FF));
    endtask

    task automatic test_unpaired_runs();
        write_paired_mode(1'b0);
        send_word(record_word(16'd5, 32'd100, 32'd200));   // first record only opens
        send_word(record_word(16'd5, 32'd100, 32'd200));
        send_word(record_word(16'd5, 32'd100, 32'd999));   // stop ignored here
        send_word(record_word(16'd5, 32'd101, 32'd150));   // closes run of three
        send_word(command_word(drh_pkg::CMD_READ, 10'd3));
        send_word(record_word(16'd5, 32'd50, 32'd10));     // out of order, dropped
        send_word(record_word(16'd4, 32'd0, 32'd0));       // lower chrom is no error
        send_word(record_word(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_word(record_word(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_word(command_word(drh_pkg::CMD_FINISH, 10'd0));
        send_word(command_word(drh_pkg::CMD_FINISH, 10'd0));   // nothing open
        send_word(command_word(drh_pkg::CMD_READ, 10'd2));
        send_word(command_word(drh_pkg::CMD_READ, 10'd1));
    endtask

    task automatic test_paired_runs();
        write_paired_mode(1'b1);
        send_word(record_word(16'd7, 32'd10, 32'd20));
        send_word(record_word(16'd7, 32'd10, 32'd20));
        send_word(record_word(16'd7, 32'd10, 32'd30));     // stop differs, new run
        send_word(record_word(16'd7, 32'd5, 32'd40));      // start back, stop up: allowed
        send_word(record_word(16'd7, 32'd4, 32'd0));       // both back, dropped
        send_word(record_word(16'd7, 32'd5, 32'd40));
        send_word(command_word(drh_pkg::CMD_FINISH, 10'd0));
        send_word(command_word(drh_pkg::CMD_READ, 10'd2));
        send_word(command_word(drh_pkg::CMD_READ, 10'd1));
    endtask

    // run longer than the top bin, so the length saturates
    task automatic test_long_run();
        write_paired_mode(1'b0);
        send_word(record_word(16'd9, 32'd0, 32'd0));
        repeat (1030)
            send_word(record_word(16'd9, 32'd0, 32'd0));
        send_word(command_word(drh_pkg::CMD_FINISH, 10'd0));
        send_word(command_word(drh_pkg::CMD_READ, 10'd1023));
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        hold_requests++;
        repeat (40)
            send_word(record_word(prev_chrom, prev_start + 32'($urandom_range(0, 1)),
                                  prev_stop));
        send_word(command_word(drh_pkg::CMD_READ, 10'd1));
    endtask

    task automatic test_random(int n_words, logic paired, int idle_pct, int stall_pct);
        int          roll;
        int          pick;
        logic [31:0] nstart;
        write_paired_mode(paired);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (n_words) begin
            roll = $urandom_range(99);
            pick = $urandom_range(9);
            if (roll < 62) begin
                // well-formed sorted stream with duplicates
                if (pick < 5) begin
                    send_word(record_word(prev_chrom, prev_start, prev_stop));
                end else if (pick < 8) begin
                    nstart = prev_start + 32'($urandom_range(1, 20));
                    send_word(record_word(prev_chrom, nstart,
                                          nstart + 32'($urandom_range(30, 200))));
                end else if (pick == 8) begin
                    send_word(record_word(prev_chrom, prev_start,
                                          prev_start + 32'($urandom_range(30, 200))));
                end else begin
                    nstart = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(1000));
                    send_word(record_word(prev_chrom + 16'($urandom_range(1, 3)), nstart,
                                          $urandom));
                end
            end else if (roll < 70) begin
                send_word(record_word(16'($urandom), $urandom, $urandom));
            end else if (roll < 76) begin
                send_word(record_word(prev_chrom, prev_start - 32'($urandom_range(1, 50)),
                                      prev_stop - 32'($urandom_range(0, 50))));
            end else if (roll < 80) begin
                send_word(command_word(drh_pkg::CMD_FINISH, 10'($urandom)));
            end else if (roll < 96) begin
                send_word(command_word(drh_pkg::CMD_READ, (pick == 0) ? 10'($urandom)
                                                                      : 10'($urandom_range(12))));
            end else begin
                send_word(command_word(CMD_UNUSED, 10'($urandom)));
            end
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= 1'b0;
        i_in_valid    <= 1'b0;
        i_in_word     <= '0;
        i_out_stall   <= 1'b0;
        foreach (model_bins[k])
            model_bins[k] = '0;
        prev_chrom   = '0;
        prev_start   = '0;
        prev_stop    = '0;
        open_run     = '0;
        run_open     = 1'b0;
        records_seen = '0;
        sort_fault   = 1'b0;
        paired_cfg   = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_after_reset();
        test_unpaired_runs();
        test_paired_runs();
        test_long_run();
        test_backpressure();
        test_random(235, 1'b0, 18, 69);
        test_random(235, 1'b1, 69, 18);
        test_random(235, 1'b0, 0, 0);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("sent %0d words, checked %0d results, longest run %0d",
                 words_sent, results_checked, longest_run);
        $display("both compare modes, order errors, saturated run length, long output hold-off");
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
